@@ rtl/scfc_pkg.sv @@
// Shared types and codes for the serial channel flag controller.
package scfc_pkg;

   // Event codes
   localparam logic [2:0] OP_FRAME   = 3'd0;
   localparam logic [2:0] OP_POLL    = 3'd1;
   localparam logic [2:0] OP_READY   = 3'd2;
   localparam logic [2:0] OP_SUSPEND = 3'd3;
   localparam logic [2:0] OP_RESUME  = 3'd4;
   localparam logic [2:0] OP_CLOSE   = 3'd5;
   localparam logic [2:0] OP_OPEN    = 3'd6;

   // Status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_BUSY         = 3'd1;
   localparam logic [2:0] ST_INVALID      = 3'd2;
   localparam logic [2:0] ST_START_FAILED = 3'd3;
   localparam logic [2:0] ST_RECV_FAILED  = 3'd4;

   // Send outcome codes (codes 2 and 3 behave as errors)
   localparam logic [1:0] SEND_MORE  = 2'd0;
   localparam logic [1:0] SEND_DONE  = 2'd1;

   // Register indexes
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_RECEIVER_MODE      = 2'd0;
   localparam logic [1:0] REG_RECEIVE_CAPABLE    = 2'd1;
   localparam logic [1:0] REG_READY_HOOK_PRESENT = 2'd2;

   typedef struct packed {
      logic [2:0] operation;
      logic       frame_is_data_in;
      logic       frame_err_in;
      logic       frame_first_in;
      logic       frame_last_in;
      logic       payload_present;
      logic       start_failed;
      logic       receive_failed;
      logic [1:0] send_outcome;
      logic       send_empty;
      logic       room_ok;
      logic       close_success;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       frame_valid;
      logic       frame_is_data_out;
      logic       frame_err_out;
      logic       frame_first_out;
      logic       frame_last_out;
      logic       frame_payload_out;
      logic       ready_pulse;
      logic       closed_event;
      logic       closed_ok;
      logic       is_open;
      logic       has_error;
   } rsp_type;

   typedef struct packed {
      logic receiver_mode;
      logic receive_capable;
      logic ready_hook_present;
   } cfg_type;

   typedef struct packed {
      logic open;
      logic opening;
      logic pending;
      logic error;
      logic suspended;
   } flags_type;

endpackage

@@ rtl/scfc_if.sv @@
// Valid/ready channel interfaces for event and result transfers.
interface scfc_req_if;
   logic              valid;
   logic              ready;
   scfc_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface scfc_rsp_if;
   logic              valid;
   logic              ready;
   scfc_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/scfc_flag_logic.sv @@
// Next-flag and result logic for one event.
module scfc_flag_logic (
   input  scfc_pkg::cfg_type   cfg,
   input  scfc_pkg::flags_type flags,
   input  scfc_pkg::req_type   req,
   output scfc_pkg::flags_type flags_next,
   output scfc_pkg::rsp_type   rsp
);

   typedef struct packed {
      scfc_pkg::flags_type f;
      logic                ready;
      logic                closed;
      logic                closed_ok;
   } work_type;

   // Close: only acts on an open channel; a failed close queues an error frame
   function automatic work_type close_step(work_type w, logic success);
      work_type r;
      r = w;
      if (w.f.open) begin
         r.f.open = 1'b0;
         if (!success) begin
            r.f.error   = 1'b1;
            r.f.pending = 1'b1;
         end
         r.closed    = 1'b1;
         r.closed_ok = success;
      end
      return r;
   endfunction

   // Open: failed start keeps the channel open with an error pending
   function automatic work_type open_step(work_type w, logic fail, logic hook);
      work_type r;
      r = w;
      if (!w.f.open) begin
         r.f.open    = 1'b1;
         r.f.pending = 1'b1;
         r.ready     = w.ready | hook;
         if (fail) begin
            r.f.error = 1'b1;
         end else begin
            r.f.error   = 1'b0;
            r.f.opening = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [2:0] open_code(work_type w, logic fail);
      return (!w.f.open && fail) ? scfc_pkg::ST_START_FAILED : scfc_pkg::ST_OK;
   endfunction

   work_type   w;
   logic [2:0] st;
   logic       done;
   logic       bad;
   logic       is_last;
   logic       fv, fdata, ferr, ffirst, flast, fpay;

   // Event decode
   always_comb begin
      w.f       = flags;
      w.ready   = 1'b0;
      w.closed  = 1'b0;
      w.closed_ok = 1'b0;
      st      = scfc_pkg::ST_OK;
      done    = 1'b0;
      bad     = req.send_outcome[1];
      is_last = (req.send_outcome == scfc_pkg::SEND_DONE) || req.send_outcome[1];
      fv      = 1'b0;
      fdata   = 1'b0;
      ferr    = 1'b0;
      ffirst  = 1'b0;
      flast   = 1'b0;
      fpay    = 1'b0;

      case (req.operation)
         scfc_pkg::OP_FRAME: begin
            if (req.frame_is_data_in) begin
               // DATA header
               if (req.frame_err_in) begin
                  w    = close_step(w, 1'b0);
                  done = 1'b1;
               end else if (req.frame_first_in) begin
                  if (w.f.open && !w.f.opening) begin
                     st   = scfc_pkg::ST_BUSY;
                     done = 1'b1;
                  end else begin
                     st = open_code(w, req.start_failed);
                     w  = open_step(w, req.start_failed, cfg.ready_hook_present);
                     if (st != scfc_pkg::ST_OK) begin
                        done = 1'b1;
                     end else begin
                        w.f.opening = 1'b0;
                     end
                  end
               end else if (!w.f.open) begin
                  st   = scfc_pkg::ST_INVALID;
                  done = 1'b1;
               end
               if (!done && req.payload_present) begin
                  if (!cfg.receive_capable) begin
                     w    = close_step(w, 1'b0);
                     st   = scfc_pkg::ST_INVALID;
                     done = 1'b1;
                  end else if (req.receive_failed) begin
                     w    = close_step(w, 1'b0);
                     st   = scfc_pkg::ST_RECV_FAILED;
                     done = 1'b1;
                  end
               end
               if (!done && req.frame_last_in) begin
                  w = close_step(w, 1'b1);
               end
            end else begin
               // ACK header
               if (req.frame_err_in) begin
                  w = close_step(w, 1'b0);
               end else if (!w.f.suspended) begin
                  if (cfg.receiver_mode) begin
                     w.ready = cfg.ready_hook_present;
                  end else begin
                     st = open_code(w, req.start_failed);
                     w  = open_step(w, req.start_failed, cfg.ready_hook_present);
                  end
               end
            end
            if (st != scfc_pkg::ST_OK) begin
               w.f.error   = 1'b1;
               w.f.pending = 1'b1;
            end
         end
         scfc_pkg::OP_POLL: begin
            if (!req.room_ok) begin
               st = scfc_pkg::ST_INVALID;
            end else if (w.f.pending) begin
               w.f.pending = 1'b0;
               if (w.f.error) begin
                  // error frame, channel drops without a close event
                  w.f.error   = 1'b0;
                  fv          = 1'b1;
                  fdata       = !cfg.receiver_mode;
                  ferr        = 1'b1;
                  ffirst      = w.f.opening;
                  w.f.opening = 1'b0;
                  flast       = 1'b1;
                  w.f.open    = 1'b0;
               end else if (w.f.open) begin
                  if (cfg.receiver_mode) begin
                     fv = 1'b1;
                  end else if (req.send_empty &&
                               (req.send_outcome == scfc_pkg::SEND_MORE)) begin
                     w.f.pending = 1'b1;
                  end else begin
                     fv          = 1'b1;
                     fdata       = 1'b1;
                     ferr        = bad;
                     ffirst      = w.f.opening;
                     w.f.opening = 1'b0;
                     flast       = is_last;
                     fpay        = !req.send_empty;
                     if (is_last) begin
                        w = close_step(w, !bad);
                     end else begin
                        w.ready = cfg.ready_hook_present;
                     end
                  end
               end
            end
         end
         scfc_pkg::OP_READY: begin
            if (!cfg.receiver_mode || w.f.opening) begin
               w.f.pending = 1'b1;
            end
         end
         scfc_pkg::OP_SUSPEND: begin
            w.f.suspended = 1'b1;
         end
         scfc_pkg::OP_RESUME: begin
            w.f.suspended = 1'b0;
            w.ready       = cfg.ready_hook_present;
         end
         scfc_pkg::OP_CLOSE: begin
            w = close_step(w, req.close_success);
         end
         scfc_pkg::OP_OPEN: begin
            st = open_code(w, req.start_failed);
            w  = open_step(w, req.start_failed, cfg.ready_hook_present);
         end
         default: begin
            st = scfc_pkg::ST_INVALID;
         end
      endcase
   end

   // Result assembly
   assign flags_next            = w.f;
   assign rsp.status            = st;
   assign rsp.frame_valid       = fv;
   assign rsp.frame_is_data_out = fdata;
   assign rsp.frame_err_out     = ferr;
   assign rsp.frame_first_out   = ffirst;
   assign rsp.frame_last_out    = flast;
   assign rsp.frame_payload_out = fpay;
   assign rsp.ready_pulse       = w.ready;
   assign rsp.closed_event      = w.closed;
   assign rsp.closed_ok         = w.closed_ok;
   assign rsp.is_open           = w.f.open;
   assign rsp.has_error         = w.f.error;

endmodule

@@ rtl/serial_channel_flag_controller_unit.sv @@
// Top level of the serial channel flag controller.
//
//  Channel   Direction  Transfer
//  req_ch    in         one event with endpoint outcomes (valid/ready)
//  rsp_ch    out        one result per event (valid/ready)
//  csr_*     in/out     APB register writes and reads, pready tied high
//
// Each event passes the input register and then the result register. One event
// per cycle is sustained while rsp_ch is ready; the flag update sits between
// the two registers and sets that rate. Synchronous active-high reset clears
// the flags and both valid bits and sets the config defaults; payload data is
// not reset. A stalled result holds and the input register fills behind it.
module serial_channel_flag_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   scfc_req_if.sink                            req_ch,
   scfc_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scfc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   scfc_pkg::cfg_type   cfg_ff, cfg_in;
   scfc_pkg::flags_type flags_ff, flags_in;
   scfc_pkg::flags_type flags_next_w;
   scfc_pkg::req_type   in_data_ff;
   scfc_pkg::rsp_type   out_data_ff, rsp_next;
   logic                in_valid_ff, in_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic                advance;
   logic                csr_write;
   logic [1:0]          csr_index;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            scfc_pkg::REG_RECEIVER_MODE:      cfg_in.receiver_mode      = csr_pwdata[0];
            scfc_pkg::REG_RECEIVE_CAPABLE:    cfg_in.receive_capable    = csr_pwdata[0];
            scfc_pkg::REG_READY_HOOK_PRESENT: cfg_in.ready_hook_present = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         scfc_pkg::REG_RECEIVER_MODE:      csr_prdata = {31'd0, cfg_ff.receiver_mode};
         scfc_pkg::REG_RECEIVE_CAPABLE:    csr_prdata = {31'd0, cfg_ff.receive_capable};
         scfc_pkg::REG_READY_HOOK_PRESENT: csr_prdata = {31'd0, cfg_ff.ready_hook_present};
         default:                          csr_prdata = 32'd0;
      endcase
   end

   // Pipeline control: move when the result register is free or draining
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign in_valid_in   = (req_ch.valid && req_ch.ready) ? 1'b1 :
                          (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in  = advance ? 1'b1 :
                          (rsp_ch.ready ? 1'b0 : out_valid_ff);
   assign flags_in      = advance ? flags_next_w : flags_ff;

   scfc_flag_logic u_flag_logic (
      .cfg        (cfg_ff),
      .flags      (flags_ff),
      .req        (in_data_ff),
      .flags_next (flags_next_w),
      .rsp        (rsp_next)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{receiver_mode: 1'b0, receive_capable: 1'b1,
                           ready_hook_present: 1'b1};
         flags_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         flags_ff     <= flags_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_data_ff <= req_ch.data;
      end
      if (advance) begin
         out_data_ff <= rsp_next;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_data_ff;

`ifndef NO_ASSERTIONS
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register not loaded after advance");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("input register lost a waiting event");

   a_frame_bits_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_data_ff.frame_valid) |->
      (!out_data_ff.frame_is_data_out && !out_data_ff.frame_err_out &&
       !out_data_ff.frame_first_out && !out_data_ff.frame_last_out &&
       !out_data_ff.frame_payload_out))
      else $error("header bits set without a frame");

   a_close_ok_event: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.closed_ok) |-> out_data_ff.closed_event)
      else $error("close success without close event");

   a_closed_not_open: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.closed_event) |-> !out_data_ff.is_open)
      else $error("channel still open after close event");
`endif

endmodule
